// File: src/mfb_pkg.sv
// Shared types and constants for the microphone sample FIFO with bias removal.
`default_nettype none
package mfb_pkg;

    // Ring buffer geometry; depth must be a power of two so the indexes wrap naturally.
    localparam int C_BUF_DEPTH = 256;
    localparam int C_IDX_W     = $clog2(C_BUF_DEPTH);
    localparam int C_FILL_W    = 8;

    // Sample formats.
    localparam int C_ADC_BITS  = 12;
    localparam int C_PCM_W     = 16;
    localparam int C_PCM_SHIFT = 4;    // times 16

    // Calibration: average of 100 samples, sum / 100 as a reciprocal multiply.
    localparam int C_CAL_SAMPLES = 100;
    localparam int C_CNT_W       = 7;
    localparam int C_SUM_W       = 19;
    localparam int C_RECIP_SHIFT = 25;
    localparam int C_RECIP       = (2 ** C_RECIP_SHIFT + C_CAL_SAMPLES - 1) / C_CAL_SAMPLES;
    localparam int C_RECIP_W     = 19;
    localparam int C_PROD_W      = C_SUM_W + C_RECIP_W;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_CAL  = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic                  fin;
        logic [C_ADC_BITS-1:0] bias;
    } t_cal_stat;

endpackage
`default_nettype wire

// File: src/mfb_ram.sv
// Simple dual-port synchronous RAM with registered read.
`default_nettype none
module mfb_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/mfb_cal.sv
// Calibration accumulator and divide-by-100 bias update.
`default_nettype none
module mfb_cal (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mfb_pkg::C_ADC_BITS-1:0] i_adc,
    output mfb_pkg::t_cal_stat                 o_stat
);
    import mfb_pkg::*;

    logic [C_SUM_W-1:0]    r_sum;
    logic [C_SUM_W-1:0]    n_sum;
    logic [C_CNT_W-1:0]    r_count;
    logic [C_ADC_BITS-1:0] r_bias;
    logic                  r_fin;
    logic [C_PROD_W-1:0]   r_prod;
    logic                  last;

    assign n_sum = r_sum + C_SUM_W'(i_adc);
    assign last  = (r_count == C_CNT_W'(C_CAL_SAMPLES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_bias  <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_fin <= i_start && last;
            if (i_start) begin
                if (last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= r_count + 1'b1;
                end
            end
            // quotient taken in the cycle after the product is registered
            if (r_fin) begin
                r_bias <= r_prod[C_RECIP_SHIFT +: C_ADC_BITS];
            end
        end
    end

    // sum * ceil(2^25/100) >> 25 is exact for sums up to 100 * 4095
    always_ff @(posedge i_clk) begin
        if (i_start && last) begin
            r_prod <= C_PROD_W'(n_sum) * C_PROD_W'(C_RECIP);
        end
    end

    assign o_stat.fin  = r_fin;
    assign o_stat.bias = r_bias;

endmodule
`default_nettype wire

// File: src/mic_sample_fifo_with_bias.sv
// Top level: microphone sample FIFO with DC bias removal.
`default_nettype none
// One operation per input transfer: push converts an ADC sample to PCM
// ((adc - bias) * 16, wrapped to 16 bits) and stores it in a 256-slot ring
// buffer that holds at most 255 samples; pop returns the oldest sample;
// calibrate accumulates samples and, on every 100th, sets the bias to the
// truncated average. Each input transfer yields exactly one output transfer
// carrying status, popped sample (zero unless a successful pop), the fill
// count after the step, the current bias and a calibration-done flag. Items
// are handled one at a time: push, the unused code and a pop on an empty
// buffer go straight to the hold state; a pop that returns data first passes
// a read state for the registered buffer RAM read, and calibrate first
// passes a divide state for the registered reciprocal multiply that
// divides by 100. While the previous result is still stalled at the output,
// the next result waits and the input stays closed until it is taken.
// Samples live in a synchronous RAM with no reset; a pop only ever reads
// slots written by an earlier push, so no clearing pass is needed.
module mic_sample_fifo_with_bias (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [1:0]                     i_operation,
    input  wire logic [mfb_pkg::C_ADC_BITS-1:0] i_adc_value,
    // output channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [1:0]                          o_status,
    output logic signed [mfb_pkg::C_PCM_W-1:0]  o_sample,
    output logic [mfb_pkg::C_FILL_W-1:0]        o_fill_count,
    output logic [mfb_pkg::C_ADC_BITS-1:0]      o_bias_value,
    output logic                                o_cal_done
);
    import mfb_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [C_IDX_W-1:0]    r_wr_idx;
    logic [C_IDX_W-1:0]    r_rd_idx;

    // pending result fields, loaded into the output register in S_HOLD
    t_status               r_status;
    logic [C_PCM_W-1:0]    r_sample;
    logic                  r_cal_done;

    // output register
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [C_PCM_W-1:0]    r_out_sample;
    logic [C_FILL_W-1:0]   r_out_fill;
    logic [C_ADC_BITS-1:0] r_out_bias;
    logic                  r_out_done;

    logic                  accept;
    logic                  out_free;
    logic                  load_out;
    logic                  full;
    logic                  empty;
    logic                  mem_we;
    logic                  mem_re;
    logic                  cal_start;
    logic [C_ADC_BITS-1:0] diff;
    logic [C_PCM_W-1:0]    pcm;
    logic [C_PCM_W-1:0]    rdata;
    t_op                   op;
    t_cal_stat             cal_stat;

    assign op       = t_op'(i_operation);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign full     = ((r_wr_idx + 1'b1) == r_rd_idx);
    assign empty    = (r_wr_idx == r_rd_idx);

    // (adc - bias) * 16 mod 2^16 only needs the low 12 bits of the difference
    assign diff = i_adc_value - cal_stat.bias;
    assign pcm  = {diff[C_PCM_W-C_PCM_SHIFT-1:0], {C_PCM_SHIFT{1'b0}}};

    assign mem_we    = accept && (op == OP_PUSH) && !full;
    assign mem_re    = accept && (op == OP_POP) && !empty;
    assign cal_start = accept && (op == OP_CAL);

    // next state
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_POP:  n_state = empty ? S_HOLD : S_READ;
                        OP_CAL:  n_state = S_DIV;
                        default: n_state = S_HOLD;
                    endcase
                end
            end
            S_READ: n_state = S_HOLD;
            S_DIV:  n_state = S_HOLD;
            S_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_wr_idx <= r_wr_idx + 1'b1;
            end
            if (mem_re) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample   <= '0;
            r_cal_done <= 1'b0;
            case (op)
                OP_PUSH: r_status <= full ? ST_FULL : ST_OK;
                OP_POP:  r_status <= empty ? ST_EMPTY : ST_OK;
                default: r_status <= ST_OK;
            endcase
        end
        if (r_state == S_READ) begin
            r_sample <= rdata;
        end
        if (r_state == S_DIV) begin
            r_cal_done <= cal_stat.fin;
        end
        if (load_out) begin
            r_out_status <= r_status;
            r_out_sample <= r_sample;
            r_out_fill   <= C_FILL_W'(r_wr_idx - r_rd_idx);
            r_out_bias   <= cal_stat.bias;
            r_out_done   <= r_cal_done;
        end
    end

    mfb_ram #(
        .ADDR_W (C_IDX_W),
        .DATA_W (C_PCM_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_idx),
        .i_wdata (pcm),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx),
        .o_rdata (rdata)
    );

    mfb_cal u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cal_start),
        .i_adc   (i_adc_value),
        .o_stat  (cal_stat)
    );

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_sample     = r_out_sample;
    assign o_fill_count = r_out_fill;
    assign o_bias_value = r_out_bias;
    assign o_cal_done   = r_out_done;

endmodule
`default_nettype wire

// File: src/mfb_checker.sv
// Port-level checker for the sample FIFO, bound to the top level.
`default_nettype none
module mfb_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_stall,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic [1:0]                     o_status,
    input wire logic [mfb_pkg::C_PCM_W-1:0]    o_sample,
    input wire logic [mfb_pkg::C_FILL_W-1:0]   o_fill_count,
    input wire logic                           o_cal_done
);
    import mfb_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample) && $stable(o_status))
        else $error("stalled output changed");

    // one item in flight: a transfer in closes the input until its result is out
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item accepted while busy");

    // empty pop reports no data and an empty buffer
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_sample == '0) && (o_fill_count == '0))
        else $error("empty pop with data or nonzero fill");

    // dropped push only happens at capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL)
            |-> (o_fill_count == C_FILL_W'(C_BUF_DEPTH - 1)) && !o_cal_done)
        else $error("full status below capacity");

endmodule

bind mic_sample_fifo_with_bias mfb_checker u_mfb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_sample     (o_sample),
    .o_fill_count (o_fill_count),
    .o_cal_done   (o_cal_done)
);
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the microphone sample FIFO with bias removal.
`timescale 1ns / 100ps

module tb_top;
    import mfb_pkg::*;

    // Watchdog: cycles without any transfer on either channel before giving up.
    localparam int STALL_LIMIT = 5000;
    // Cycles to watch for stray results once nothing is outstanding.
    localparam int TAIL_CYCLES = 20;
    // Random stimulus modes.
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;
    localparam int MODE_CALIB = 3;

    typedef struct packed {
        t_status                     status;
        logic signed [C_PCM_W-1:0]   sample;
        logic [C_FILL_W-1:0]         fill;
        logic [C_ADC_BITS-1:0]       bias;
        logic                        done;
    } t_mic_result;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_valid     = 1'b0;
    logic [1:0]                  i_operation = '0;
    logic [C_ADC_BITS-1:0]       i_adc_value = '0;
    logic                        i_stall     = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [1:0]                  o_status;
    logic signed [C_PCM_W-1:0]   o_sample;
    logic [C_FILL_W-1:0]         o_fill_count;
    logic [C_ADC_BITS-1:0]       o_bias_value;
    logic                        o_cal_done;

    // Shadow copy of the FIFO and the calibration state.
    logic [C_PCM_W-1:0]          ring_pcm [C_BUF_DEPTH];
    logic [C_IDX_W-1:0]          ring_wr  = '0;
    logic [C_IDX_W-1:0]          ring_rd  = '0;
    logic [C_ADC_BITS-1:0]       bias_now = '0;
    logic [C_SUM_W-1:0]          cal_acc  = '0;
    logic [C_CNT_W-1:0]          cal_n    = '0;

    t_mic_result                 pending_results [$];
    int                          err_count     = 0;
    int                          quiet_cycles  = 0;
    int                          src_idle_pct  = 0;
    int                          dst_stall_pct = 0;

    mic_sample_fifo_with_bias DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_adc_value  (i_adc_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_sample     (o_sample),
        .o_fill_count (o_fill_count),
        .o_bias_value (o_bias_value),
        .o_cal_done   (o_cal_done)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Expected result of one operation; advances the shadow state.
    function automatic t_mic_result mic_fifo_predict(t_op op, logic [C_ADC_BITS-1:0] adc);
        t_mic_result r;
        logic [C_PCM_W-1:0] pcm;
        r.status = ST_OK;
        r.sample = '0;
        r.done   = 1'b0;
        case (op)
            OP_PUSH: begin
                // one slot always stays free, so "next write == read" means full
                if (C_IDX_W'(ring_wr + 1'b1) != ring_rd) begin
                    // unsigned difference wraps; only the low 16 bits survive
                    pcm = ({4'd0, adc} - {4'd0, bias_now}) << C_PCM_SHIFT;
                    ring_pcm[ring_wr] = pcm;
                    ring_wr = ring_wr + 1'b1;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_POP: begin
                if (ring_wr != ring_rd) begin
                    r.sample = ring_pcm[ring_rd];
                    ring_rd = ring_rd + 1'b1;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            OP_CAL: begin
                cal_acc = cal_acc + adc;
                cal_n   = cal_n + 1'b1;
                if (cal_n >= C_CAL_SAMPLES) begin
                    bias_now = C_ADC_BITS'(cal_acc / C_CAL_SAMPLES);
                    cal_acc  = '0;
                    cal_n    = '0;
                    r.done   = 1'b1;
                end
            end
            default: begin
                // unused code: no state change
            end
        endcase
        r.fill = ring_wr - ring_rd;
        r.bias = bias_now;
        return r;
    endfunction

    function automatic int ring_fill();
        return int'(C_FILL_W'(ring_wr - ring_rd));
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Output check first, then prediction for the input transfer of the same edge;
    // one process owns the queue so the edge ordering never matters.
    always @(posedge i_clk) begin : scoreboard
        t_mic_result exp_r;
        if (!i_rst_n) begin
            ring_wr  = '0;
            ring_rd  = '0;
            bias_now = '0;
            cal_acc  = '0;
            cal_n    = '0;
            pending_results.delete();
        end else begin
            if (o_valid === 1'b1 && i_stall == 1'b0) begin
                if (pending_results.size() == 0) begin
                    err_count++;
                    $display("%0t: result expected none, got status %0d sample %0d",
                             $time, o_status, o_sample);
                end else begin
                    exp_r = pending_results.pop_front();
                    check_field("status", exp_r.status, o_status);
                    check_field("sample", exp_r.sample, o_sample);
                    check_field("fill_count", exp_r.fill, o_fill_count);
                    check_field("bias_value", exp_r.bias, o_bias_value);
                    check_field("cal_done", exp_r.done, o_cal_done);
                end
            end
            if (i_valid && o_stall === 1'b0)
                pending_results.push_back(mic_fifo_predict(t_op'(i_operation), i_adc_value));
        end
    end

    // Receiver backpressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < dst_stall_pct);
    end

    // Watchdog on transfers of either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Entered at a falling edge; returns at the falling edge after the transfer.
    // valid stays high into the next call when no gap is drawn.
    task automatic send_op(input t_op op, input logic [C_ADC_BITS-1:0] adc);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_adc_value <= adc;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic bus_quiet();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain_wait();
        bus_quiet();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_idling(input int src_pct, input int dst_pct);
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
    endtask

    // Mostly uniform, with rails and values near the bias (zero-crossing PCM).
    function automatic logic [C_ADC_BITS-1:0] pick_adc();
        int v;
        case ($urandom_range(9))
            0: v = 0;
            1: v = (1 << C_ADC_BITS) - 1;
            2: begin
                v = int'(bias_now) + int'($urandom_range(16)) - 8;
                if (v < 0) v = 0;
                if (v > (1 << C_ADC_BITS) - 1) v = (1 << C_ADC_BITS) - 1;
            end
            default: v = $urandom_range((1 << C_ADC_BITS) - 1);
        endcase
        return C_ADC_BITS'(v);
    endfunction

    // Empty pops, rails with zero bias, unused code, a lone calibration sample.
    task automatic test_directed();
        send_op(OP_POP, 12'd0);
        send_op(OP_NOP, 12'hFFF);
        send_op(OP_NOP, 12'h000);
        send_op(OP_PUSH, 12'h000);
        send_op(OP_PUSH, 12'hFFF);
        send_op(OP_PUSH, 12'h800);
        send_op(OP_PUSH, 12'h001);
        send_op(OP_NOP, 12'h555);
        send_op(OP_POP, 12'hFFF);
        send_op(OP_POP, 12'h000);
        send_op(OP_CAL, 12'hABC);
        send_op(OP_POP, 12'h123);
        send_op(OP_POP, 12'h000);
        send_op(OP_POP, 12'h000);
        send_op(OP_PUSH, 12'h7FF);
        send_op(OP_POP, 12'h000);
        bus_quiet();
    endtask

    // Bias to the top rail, then pushes whose PCM wraps, then a fresh random bias.
    task automatic test_calibration();
        while (cal_n != 0) send_op(OP_CAL, pick_adc());
        repeat (C_CAL_SAMPLES) send_op(OP_CAL, 12'hFFF);
        send_op(OP_PUSH, 12'h000);
        send_op(OP_PUSH, 12'hFFF);
        send_op(OP_PUSH, 12'h800);
        repeat (3) send_op(OP_POP, 12'h000);
        repeat (C_CAL_SAMPLES) send_op(OP_CAL, C_ADC_BITS'($urandom_range(4095)));
        send_op(OP_PUSH, pick_adc());
        send_op(OP_POP, 12'h000);
        bus_quiet();
    endtask

    // Fill to capacity, push into a full buffer, then drain past empty.
    task automatic test_fill_and_drain();
        while (ring_fill() < C_BUF_DEPTH - 1) send_op(OP_PUSH, pick_adc());
        repeat (3) send_op(OP_PUSH, pick_adc());
        while (ring_fill() > 0) send_op(OP_POP, pick_adc());
        repeat (2) send_op(OP_POP, pick_adc());
        bus_quiet();
    endtask

    // Bursts biased toward filling, draining, mixing or calibrating.
    task automatic test_random(input int n_items);
        int sent;
        int burst;
        int mode;
        int r;
        t_op op;
        sent = 0;
        while (sent < n_items) begin
            mode  = $urandom_range(3);
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                r = $urandom_range(99);
                case (mode)
                    MODE_FILL:  op = (r < 75) ? OP_PUSH : (r < 90) ? OP_POP :
                                     (r < 97) ? OP_CAL : OP_NOP;
                    MODE_DRAIN: op = (r < 70) ? OP_POP : (r < 92) ? OP_PUSH :
                                     (r < 97) ? OP_CAL : OP_NOP;
                    MODE_CALIB: op = (r < 80) ? OP_CAL : (r < 90) ? OP_PUSH : OP_POP;
                    default:    op = t_op'($urandom_range(3));
                endcase
                send_op(op, pick_adc());
                sent++;
                // sender pause mid-test until the pipeline is empty
                if (sent == n_items / 2) drain_wait();
            end
        end
        bus_quiet();
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_idling(0, 0);
        test_directed();
        test_random(180);

        set_idling(64, 0);
        test_calibration();
        test_random(180);

        set_idling(0, 64);
        test_fill_and_drain();
        test_random(180);

        set_idling(33, 33);
        test_random(180);

        drain_wait();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
